// File: rtl/core/h2nm_pkg.sv
`timescale 1ns / 1ps
package h2nm_pkg;

    localparam int X_W      = 8;
    localparam int Y_W      = 8;
    localparam int H_W      = 8;
    localparam int SIZE_W   = 9;
    localparam int ADDR_W   = X_W + Y_W;
    localparam int Q_W      = 17;   // Q1.16 values, below 2.0
    localparam int CNT_W    = 2;

    localparam logic [SIZE_W-1:0] MAX_WIDTH    = 9'd256;
    localparam logic [SIZE_W-1:0] MAX_HEIGHT   = 9'd256;
    localparam logic [SIZE_W-1:0] SIZE_RESET   = 9'd256;
    localparam logic [CNT_W-1:0]  CNT_LAST     = 2'd2;
    localparam logic [1:0]        NEWTON_LAST  = 2'd3;
    localparam logic [Q_W-1:0]    Q_ONE        = 17'h10000;
    localparam logic [17:0]       S_DIVISOR    = 18'd260100;
    localparam logic [17:0]       THREE_HALVES = 18'd196608;
    localparam logic [7:0]        ALPHA        = 8'hFF;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        DP_NOP, DP_WRITE, DP_READ, DP_DIFF, DP_START_S, DP_DIV_STEP, DP_END_S,
        DP_NT_T, DP_NT_U, DP_NT_R, DP_START_A, DP_END_A, DP_START_B, DP_END_B,
        DP_OUT_PIX, DP_OUT_ERR
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] nbr;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic in_range;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/core/h2nm_dp.sv
`timescale 1ns / 1ps
module h2nm_dp import h2nm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_capture,
    input  logic              i_operation,
    input  logic [X_W-1:0]    i_x_coord,
    input  logic [Y_W-1:0]    i_y_coord,
    input  logic [H_W-1:0]    i_height_sample,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [31:0]       o_normal_pixel,
    output logic              o_coord_error
);

    function automatic logic [7:0] to_channel(input logic [17:0] v);
        logic [25:0] m;
        m = {v, 8'b0} - 26'(v);
        return (m[25:17] > 9'd255) ? 8'hFF : m[24:17];
    endfunction

    // floor(n / 255) as n * ceil(2^40 / 255) >> 40, exact for any 25-bit n
    function automatic logic [17:0] div255(input logic [24:0] n);
        logic [57:0] p;
        p = (58'(n) << 32) + (58'(n) << 24) + (58'(n) << 16)
            + (58'(n) << 8) + (58'(n) << 1);
        return p[57:40];
    endfunction

    logic [SIZE_W-1:0] r_width, r_height;
    logic              r_op;
    logic [X_W-1:0]    r_x;
    logic [Y_W-1:0]    r_y;
    logic [H_W-1:0]    r_hs;
    logic [H_W-1:0]    mem [0:(1<<ADDR_W)-1];
    logic [H_W-1:0]    r_h [0:3];
    logic signed [8:0] r_a, r_b;
    logic [24:0]       r_dn;
    logic [10:0]       r_q1;
    logic [Q_W-1:0]    r_s, r_r, r_t, r_mag_a, r_mag_b;
    logic [17:0]       r_u;
    logic              r_o_valid, r_o_err;
    logic [31:0]       r_o_pix;

    logic [SIZE_W-1:0] w_eff, h_eff, wm1, hm1, x1, y1;
    logic [X_W-1:0]    xp, xm;
    logic [Y_W-1:0]    yp, ym;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [17:0] pa, pb;
    logic [18:0]       sum_s;
    logic [17:0]       dq;
    logic [18:0]       rem1;
    logic [33:0]       p_t, p_u;
    logic [17:0]       wv;
    logic [34:0]       p_r;
    logic [7:0]        abs_v;
    logic [24:0]       p_c;
    logic [17:0]       v_r, v_g, v_b;

    always_comb begin
        w_eff = (r_width == '0) ? 9'd1 : ((r_width > MAX_WIDTH) ? MAX_WIDTH : r_width);
        h_eff = (r_height == '0) ? 9'd1 : ((r_height > MAX_HEIGHT) ? MAX_HEIGHT : r_height);
        wm1 = w_eff - 9'd1;
        hm1 = h_eff - 9'd1;
        x1 = {1'b0, r_x} + 9'd1;
        y1 = {1'b0, r_y} + 9'd1;
        // wrap at the configured edges
        xp = (x1 >= w_eff) ? '0 : x1[X_W-1:0];
        xm = (r_x == '0) ? wm1[X_W-1:0] : r_x - 8'd1;
        yp = (y1 >= h_eff) ? '0 : y1[Y_W-1:0];
        ym = (r_y == '0) ? hm1[Y_W-1:0] : r_y - 8'd1;
        case (i_cmd.nbr)
            2'd0:    rd_addr = {r_y, xp};
            2'd1:    rd_addr = {r_y, xm};
            2'd2:    rd_addr = {yp, r_x};
            default: rd_addr = {ym, r_x};
        endcase

        pa = r_a * r_a;
        pb = r_b * r_b;
        sum_s = 19'(pa[15:0]) + 19'(pb[15:0]) + 19'(S_DIVISOR);

        dq   = div255(r_dn);
        rem1 = r_dn[18:0] - ({r_q1, 8'b0} - 19'(r_q1));

        p_t = r_r * r_r;
        p_u = r_s * r_t;
        wv = (r_u < THREE_HALVES) ? THREE_HALVES - r_u : '0;
        p_r = r_r * wv;

        if (i_cmd.op == DP_START_A) begin
            abs_v = r_a[8] ? 8'(-r_a) : r_a[7:0];
        end else begin
            abs_v = r_b[8] ? 8'(-r_b) : r_b[7:0];
        end
        p_c = abs_v * r_r;

        // component is minus the difference, scaled
        v_r = (r_a > 0) ? 18'(Q_ONE) - 18'(r_mag_a) : 18'(Q_ONE) + 18'(r_mag_a);
        v_g = (r_b > 0) ? 18'(Q_ONE) - 18'(r_mag_b) : 18'(Q_ONE) + 18'(r_mag_b);
        v_b = 18'(Q_ONE) + 18'(r_r);
    end

    assign o_status.is_query = r_op;
    assign o_status.in_range = ({1'b0, r_x} < w_eff) && ({1'b0, r_y} < h_eff);
    assign o_status.out_free = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= SIZE_RESET;
            r_height  <= SIZE_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_width <= i_cfg_data;
                end else begin
                    r_height <= i_cfg_data;
                end
            end
            if (i_cmd.op == DP_OUT_PIX || i_cmd.op == DP_OUT_ERR) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // single-port height store
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_WRITE) begin
            mem[{r_y, r_x}] <= r_hs;
        end else if (i_cmd.op == DP_READ) begin
            r_h[i_cmd.nbr] <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_op <= i_operation;
            r_x  <= i_x_coord;
            r_y  <= i_y_coord;
            r_hs <= i_height_sample;
        end
        case (i_cmd.op)
            DP_DIFF: begin
                r_a <= $signed({1'b0, r_h[0]}) - $signed({1'b0, r_h[1]});
                r_b <= $signed({1'b0, r_h[2]}) - $signed({1'b0, r_h[3]});
            end
            // S << 16 / 260100 = S << 14 / (255 * 255); S = 255 * q1 + r1
            DP_START_S: r_dn <= 25'(sum_s);
            DP_DIV_STEP: begin
                case (i_cmd.nbr)
                    2'd0:    r_q1 <= dq[10:0];
                    2'd1:    r_dn <= {3'b0, rem1[7:0], 14'b0};
                    default: r_dn <= {r_q1, dq[13:0]};
                endcase
            end
            // |d| * r / 510 = (|d| * r / 2) / 255
            DP_START_A, DP_START_B: r_dn <= {1'b0, p_c[24:1]};
            DP_END_S: begin
                r_s <= dq[Q_W-1:0];
                r_r <= Q_ONE;
            end
            DP_NT_T: r_t <= p_t[32:16];
            DP_NT_U: r_u <= p_u[33:16];
            DP_NT_R: r_r <= p_r[33:17];
            DP_END_A: r_mag_a <= dq[Q_W-1:0];
            DP_END_B: r_mag_b <= dq[Q_W-1:0];
            DP_OUT_PIX: begin
                r_o_pix <= {ALPHA, to_channel(v_r), to_channel(v_g), to_channel(v_b)};
                r_o_err <= 1'b0;
            end
            DP_OUT_ERR: begin
                r_o_pix <= '0;
                r_o_err <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_o_valid;
    assign o_normal_pixel = r_o_pix;
    assign o_coord_error  = r_o_err;

endmodule

// File: rtl/core/h2nm_ctrl.sv
`timescale 1ns / 1ps
module h2nm_ctrl import h2nm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_WRITE, S_READ, S_DIFF, S_START_S, S_DIV_S, S_END_S,
        S_NT_T, S_NT_U, S_NT_R, S_START_A, S_END_A, S_START_B,
        S_END_B, S_OUT, S_ERR
    } t_state;

    t_state           r_state;
    logic             r_in_ready;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       r_step;

    always_comb begin
        o_cmd.nbr = r_cnt;
        case (r_state)
            S_WRITE:   o_cmd.op = DP_WRITE;
            S_READ:    o_cmd.op = DP_READ;
            S_DIFF:    o_cmd.op = DP_DIFF;
            S_START_S: o_cmd.op = DP_START_S;
            S_DIV_S:   o_cmd.op = DP_DIV_STEP;
            S_END_S:   o_cmd.op = DP_END_S;
            S_NT_T:    o_cmd.op = DP_NT_T;
            S_NT_U:    o_cmd.op = DP_NT_U;
            S_NT_R:    o_cmd.op = DP_NT_R;
            S_START_A: o_cmd.op = DP_START_A;
            S_END_A:   o_cmd.op = DP_END_A;
            S_START_B: o_cmd.op = DP_START_B;
            S_END_B:   o_cmd.op = DP_END_B;
            S_OUT:     o_cmd.op = i_status.out_free ? DP_OUT_PIX : DP_NOP;
            S_ERR:     o_cmd.op = i_status.out_free ? DP_OUT_ERR : DP_NOP;
            default:   o_cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_cnt      <= '0;
            r_step     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_in_ready <= 1'b0;
                        r_state    <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_cnt <= '0;
                    if (!i_status.is_query) begin
                        if (i_status.in_range) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_in_ready <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end else if (i_status.in_range) begin
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_ERR;
                    end
                end
                S_WRITE: begin
                    r_in_ready <= 1'b1;
                    r_state    <= S_IDLE;
                end
                S_READ: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF:    r_state <= S_START_S;
                S_START_S: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV_S;
                end
                S_DIV_S: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_END_S;
                    end
                end
                S_END_S: begin
                    r_step  <= '0;
                    r_state <= S_NT_T;
                end
                S_NT_T: r_state <= S_NT_U;
                S_NT_U: r_state <= S_NT_R;
                S_NT_R: begin
                    r_step <= r_step + 2'd1;
                    r_state <= (r_step == NEWTON_LAST) ? S_START_A : S_NT_T;
                end
                S_START_A: r_state <= S_END_A;
                S_END_A:   r_state <= S_START_B;
                S_START_B: r_state <= S_END_B;
                S_END_B:   r_state <= S_OUT;
                S_OUT, S_ERR: begin
                    if (i_status.out_free) begin
                        r_in_ready <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_in_ready <= 1'b1;
                    r_state    <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

// File: rtl/core/height_to_normal_map_core.sv
`timescale 1ns / 1ps
// Height map store with normal-map queries. A load item writes one 8-bit
// height into a 64K-entry single-port store. A query item reads its four
// wrapped neighbours one per cycle, divides the squared length by 260100 in
// three reciprocal-multiply steps, runs a Newton reciprocal square root, then
// scales each slope component by that root over 510. The controller is ready
// for the next item once the result is written into the output register, and
// the next item is accepted while the result waits there. Loads outside the
// configured size are dropped; queries outside it return coord_error.
module height_to_normal_map_core import h2nm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [X_W-1:0]    i_x_coord,
    input  logic [Y_W-1:0]    i_y_coord,
    input  logic [H_W-1:0]    i_height_sample,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [31:0]       o_normal_pixel,
    output logic              o_coord_error
);

    t_dp_cmd    cmd;
    t_dp_status status;

    h2nm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    h2nm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_capture       (i_in_valid && o_in_ready),
        .i_operation     (i_operation),
        .i_x_coord       (i_x_coord),
        .i_y_coord       (i_y_coord),
        .i_height_sample (i_height_sample),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_normal_pixel  (o_normal_pixel),
        .o_coord_error   (o_coord_error)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after an item was taken");

    a_err_zero_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_coord_error) |-> (o_normal_pixel == '0))
        else $error("coordinate error with nonzero pixel");

    a_alpha_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_coord_error) |-> (o_normal_pixel[31:24] == ALPHA))
        else $error("normal pixel without full alpha");

endmodule

// File: tb/h2nm_tb_pkg.sv
`timescale 1ns / 1ps
package h2nm_tb_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

// File: tb/height_to_normal_map_checker.sv
`timescale 1ns / 1ps
module height_to_normal_map_checker import h2nm_pkg::*, h2nm_tb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_operation,
    input  logic [X_W-1:0]    i_x_coord,
    input  logic [Y_W-1:0]    i_y_coord,
    input  logic [H_W-1:0]    i_height_sample,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [31:0]       i_normal_pixel,
    input  logic              i_coord_error,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_queries,
    output int                o_off_grid
);

    typedef struct packed {
        logic [31:0] pixel;
        logic        err;
    } t_pixel_result;

    logic [H_W-1:0]  heights [0:(1 << ADDR_W) - 1];
    logic [SIZE_W-1:0] width_raw, height_raw;
    t_pixel_result   pixel_queue [$];

    function automatic int unsigned clamp_size(logic [SIZE_W-1:0] raw, logic [SIZE_W-1:0] maxv);
        if (raw == 0) return 1;
        if (raw > maxv) return maxv;
        return raw;
    endfunction

    function automatic longint channel_of(longint c);
        longint v, ch;
        v = c + 65536;
        if (v < 0) v = 0;
        ch = (v * 255) >>> 17;
        return (ch > 255) ? 255 : ch;
    endfunction

    // slope component is the negated difference scaled by r/510, truncated toward zero
    function automatic longint slope_comp(longint d, longint r);
        longint mag;
        mag = ((d < 0 ? -d : d) * r) / 510;
        return (d > 0) ? -mag : mag;
    endfunction

    function automatic logic [31:0] shade(longint a, longint b);
        longint s, r, t, u, wv;
        logic [7:0] cr, cg, cb;
        s = ((a * a + b * b + 260100) << 16) / 260100;
        r = 65536;
        for (int i = 0; i < 4; i++) begin
            t  = (r * r) >>> 16;
            u  = (s * t) >>> 16;
            wv = (u < 196608) ? 196608 - u : 0;
            r  = (r * wv) >>> 17;
        end
        cr = 8'(channel_of(slope_comp(a, r)));
        cg = 8'(channel_of(slope_comp(b, r)));
        cb = 8'(channel_of(r));
        return {ALPHA, cr, cg, cb};
    endfunction

    function automatic longint height_at(int unsigned x, int unsigned y);
        return heights[{8'(y), 8'(x)}];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        int unsigned w, h, x, y, xp, xm, yp, ym;
        t_pixel_result res, want;
        if (!i_rst_n) begin
            width_raw  <= SIZE_RESET;
            height_raw <= SIZE_RESET;
            pixel_queue.delete();
            o_fail_count = 0;
            o_queries    = 0;
            o_off_grid   = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WIDTH) width_raw <= i_cfg_data;
                else height_raw <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                w = clamp_size(width_raw, MAX_WIDTH);
                h = clamp_size(height_raw, MAX_HEIGHT);
                x = i_x_coord;
                y = i_y_coord;
                if (i_operation == OP_LOAD) begin
                    if (x < w && y < h) heights[{i_y_coord, i_x_coord}] = i_height_sample;
                end else begin
                    o_queries++;
                    if (x >= w || y >= h) begin
                        res.pixel = '0;
                        res.err   = 1'b1;
                        o_off_grid++;
                    end else begin
                        xp = (x + 1 >= w) ? 0 : x + 1;
                        xm = (x == 0) ? w - 1 : x - 1;
                        yp = (y + 1 >= h) ? 0 : y + 1;
                        ym = (y == 0) ? h - 1 : y - 1;
                        res.pixel = shade(height_at(xp, y) - height_at(xm, y),
                                          height_at(x, yp) - height_at(x, ym));
                        res.err   = 1'b0;
                    end
                    pixel_queue.insert(pixel_queue.size(), res);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (pixel_queue.size() == 0) begin
                    report_mismatch("unexpected item", i_normal_pixel, '0);
                end else begin
                    want = pixel_queue.pop_front();
                    if (i_normal_pixel !== want.pixel)
                        report_mismatch("normal_pixel", i_normal_pixel, want.pixel);
                    if (i_coord_error !== want.err)
                        report_mismatch("coord_error", 32'(i_coord_error), 32'(want.err));
                end
            end
        end
        o_pending = pixel_queue.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top import h2nm_pkg::*, h2nm_tb_pkg::*;;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = CFG_WIDTH;
    logic [SIZE_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_operation = OP_LOAD;
    logic [X_W-1:0]    i_x_coord = '0;
    logic [Y_W-1:0]    i_y_coord = '0;
    logic [H_W-1:0]    i_height_sample = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [31:0]       o_normal_pixel;
    logic              o_coord_error;

    int fail_count, pending, queries, off_grid;
    int n_items = 0, n_configs = 0, burst_left = 0, idle_cycles = 0;
    int unsigned cur_w = 256, cur_h = 256;
    bit hold_req = 0;
    bit written [0:(1 << ADDR_W) - 1];

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 120;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    height_to_normal_map_core u_top (.*);

    height_to_normal_map_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_operation, .i_x_coord, .i_y_coord,
        .i_height_sample, .i_out_valid(o_out_valid), .i_out_ready,
        .i_normal_pixel(o_normal_pixel), .i_coord_error(o_coord_error),
        .o_fail_count(fail_count), .o_pending(pending), .o_queries(queries),
        .o_off_grid(off_grid)
    );

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall segments, plus one long hold-off on request
    initial begin
        int mode, len;
        forever begin
            if (hold_req) begin
                hold_req = 0;
                @(negedge i_clk) i_out_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end else begin
                mode = $urandom_range(0, 2);
                len  = $urandom_range(5, 40);
                repeat (len) @(negedge i_clk)
                    i_out_ready <= (mode == 0) ? 1'b1 :
                                   (mode == 1) ? 1'($urandom_range(0, 1)) :
                                   ($urandom_range(0, 7) == 0);
            end
        end
    end

    function automatic int unsigned clamp_size(int unsigned raw);
        if (raw == 0) return 1;
        if (raw > 256) return 256;
        return raw;
    endfunction

    task automatic push_item(logic op, int unsigned x, int unsigned y, int unsigned h);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_x_coord       <= 8'(x);
        i_y_coord       <= 8'(y);
        i_height_sample <= 8'(h);
        burst_left--;
        n_items++;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
    endtask

    task automatic load_at(int unsigned x, int unsigned y, int unsigned h);
        push_item(OP_LOAD, x, y, h);
        if (x < cur_w && y < cur_h) written[{8'(y), 8'(x)}] = 1;
    endtask

    task automatic fill_if_blank(int unsigned x, int unsigned y);
        if (!written[{8'(y), 8'(x)}]) load_at(x, y, $urandom_range(0, 255));
    endtask

    // in-grid queries first load any neighbor that was never written
    task automatic query_at(int unsigned x, int unsigned y);
        if (x < cur_w && y < cur_h) begin
            fill_if_blank((x + 1 >= cur_w) ? 0 : x + 1, y);
            fill_if_blank((x == 0) ? cur_w - 1 : x - 1, y);
            fill_if_blank(x, (y + 1 >= cur_h) ? 0 : y + 1);
            fill_if_blank(x, (y == 0) ? cur_h - 1 : y - 1);
        end
        push_item(OP_QUERY, x, y, $urandom_range(0, 255));
    endtask

    task automatic drain;
        @(negedge i_clk) i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_size(int unsigned w_raw, int unsigned h_raw);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= 9'(w_raw);
        @(negedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data  <= 9'(h_raw);
        @(negedge i_clk) i_cfg_we <= 1'b0;
        cur_w = clamp_size(w_raw);
        cur_h = clamp_size(h_raw);
        n_configs++;
    endtask

    initial begin
        int unsigned w_raws [9] = '{256, 3, 0, 1, 2, 511, 17, 256, 5};
        int unsigned h_raws [9] = '{256, 2, 0, 5, 1, 300, 9, 2, 256};
        int r;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        for (int p = 0; p < 9; p++) begin
            set_size(w_raws[p], h_raws[p]);
            if (p == 0) begin
                // steepest slopes, both wrapped at the origin
                load_at(1, 0, 255);
                load_at(255, 0, 0);
                load_at(0, 1, 0);
                load_at(0, 255, 255);
                query_at(0, 0);
                load_at(254, 255, 255);
                load_at(0, 255, 0);
                query_at(255, 255);
                query_at(128, 127);
            end else if (p == 1) begin
                load_at(3, 0, 77);      // beyond width: dropped
                load_at(0, 2, 77);      // beyond height: dropped
                query_at(3, 0);
                query_at(0, 2);
                query_at(255, 255);
                query_at(2, 1);
                query_at(0, 0);
            end else if (p == 2) begin
                load_at(0, 0, 255);     // one-pixel image: zero differences
                query_at(0, 0);
                query_at(1, 0);
            end
            if (p == 5) hold_req = 1;
            repeat (26) begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    query_at($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
                else if (r < 80)
                    query_at($urandom_range(0, 255), $urandom_range(0, 255));
                else
                    load_at($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255));
            end
        end
        drain();

        $display("ran %0d items over %0d size settings: %0d queries, %0d off the grid",
                 n_items, n_configs, queries, off_grid);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
